// ===== rtl/one_button_mode_controller_defines.svh =====
// ----------------------------------------------------------------------------
// One-button mode controller assertion macros
// Shared property macros on the controller clock and synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ONE_BUTTON_MODE_CONTROLLER_DEFINES_SVH
`define ONE_BUTTON_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OBMC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define OBMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/obmc_pkg.sv =====
// ----------------------------------------------------------------------------
// One-button mode controller package
// Widths, mode and event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package obmc_pkg;

   localparam int MODE_W      = 3;
   localparam int EVENT_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int COUNT_W     = 8;

   // Mode codes.
   localparam logic [MODE_W-1:0] MODE_OFF  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TIME = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HOUR = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MIN  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SEC  = 3'd4;

   // Event codes.
   localparam logic [EVENT_W-1:0] EV_NONE  = 3'd0;
   localparam logic [EVENT_W-1:0] EV_FAST  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_FOUR  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_EIGHT = 3'd3;
   localparam logic [EVENT_W-1:0] EV_IDLE  = 3'd4;

   // Input operation codes.
   localparam logic OP_BLINK  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // LED selection mask.
   localparam int LED_RED_BIT   = 0;
   localparam int LED_GREEN_BIT = 1;
   localparam logic [1:0] LED_NONE  = 2'b00;
   localparam logic [1:0] LED_RED   = 2'b01;
   localparam logic [1:0] LED_GREEN = 2'b10;
   localparam logic [1:0] LED_BOTH  = 2'b11;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_PRESS_LIMIT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_LIMIT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LIMIT         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_PERIOD       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_TICKS_SHOW_TIME = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_TICKS_ADJUST    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_TICKS_SECONDS   = 3'd6;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] RST_FAST_PRESS_LIMIT   = 8'd50;
   localparam logic [CSR_DATA_W-1:0] RST_LONG_PRESS_LIMIT   = 8'd100;
   localparam logic [CSR_DATA_W-1:0] RST_IDLE_LIMIT         = 8'd250;
   localparam logic [CSR_DATA_W-1:0] RST_BLINK_PERIOD       = 8'd20;
   localparam logic [CSR_DATA_W-1:0] RST_ON_TICKS_SHOW_TIME = 8'd18;
   localparam logic [CSR_DATA_W-1:0] RST_ON_TICKS_ADJUST    = 8'd10;
   localparam logic [CSR_DATA_W-1:0] RST_ON_TICKS_SECONDS   = 8'd2;

   // Press counts at which the warning flash toggles the LEDs.
   localparam logic [COUNT_W-1:0] WARN_OFF_FIRST = 8'd46;
   localparam logic [COUNT_W-1:0] WARN_ON        = 8'd48;
   localparam logic [COUNT_W-1:0] WARN_OFF_LAST  = 8'd50;

   typedef struct packed {
      logic               red_led;
      logic               green_led;
      logic [MODE_W-1:0]  mode;
      logic [EVENT_W-1:0] event_code;
   } rsp_type;

endpackage

// ===== rtl/one_button_mode_controller.sv =====
// Each result beat is registered: it enters the output register, or the skid entry while rsp is stalled.
// Throughput: one request beat per cycle while req_stall is low.
// A two-entry output buffer lets one more request in while a result is stalled.
// Reset is synchronous and active high; it restores all register reset values,
// puts the controller in off mode and empties the output buffer.
// ----------------------------------------------------------------------------
// One-button mode controller
// Press timing, inactivity detection, five-mode machine and LED blink control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module one_button_mode_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic                                 req_button_pressed,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_red_led,
   output logic                                 rsp_green_led,
   output logic [obmc_pkg::MODE_W-1:0]          rsp_mode,
   output logic [obmc_pkg::EVENT_W-1:0]         rsp_event_code,
   input  logic                                 csr_write_en,
   input  logic [obmc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [obmc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import obmc_pkg::*;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] fast_limit_ff, long_limit_ff, idle_limit_ff, blink_period_ff;
   logic [CSR_DATA_W-1:0] on_show_ff, on_adjust_ff, on_seconds_ff;

   // Controller state.
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic               red_ff, red_in;
   logic               green_ff, green_in;
   logic [COUNT_W-1:0] blink_count_ff, blink_count_in;
   logic [COUNT_W-1:0] on_ticks_ff, on_ticks_in;
   logic [1:0]         blink_leds_ff, blink_leds_in;
   logic [COUNT_W-1:0] press_count_ff, press_count_in;
   logic [COUNT_W-1:0] idle_count_ff, idle_count_in;
   logic               sampler_on_ff, sampler_on_in;

   // Output buffer.
   logic    rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_data_ff, skid_data_ff;

   logic               accept, pop;
   logic               raise;
   logic [EVENT_W-1:0] ev;
   logic [MODE_W-1:0]  target_mode;
   logic [COUNT_W:0]   blink_next;
   rsp_type            result;

   function automatic logic [EVENT_W-1:0] sort_event(
      input logic [COUNT_W-1:0] press,
      input logic [COUNT_W-1:0] idle,
      input logic [CSR_DATA_W-1:0] fast_lim,
      input logic [CSR_DATA_W-1:0] long_lim,
      input logic [CSR_DATA_W-1:0] idle_lim
   );
      logic [EVENT_W-1:0] code;
      if (idle >= idle_lim) begin
         code = EV_IDLE;
      end else if (press != '0 && press < fast_lim) begin
         code = EV_FAST;
      end else if (press >= fast_lim && press < long_lim) begin
         code = EV_FOUR;
      end else begin
         code = EV_EIGHT;
      end
      return code;
   endfunction

   function automatic logic [MODE_W-1:0] step_mode(
      input logic [MODE_W-1:0]  cur,
      input logic [EVENT_W-1:0] code
   );
      logic [MODE_W-1:0] nxt;
      nxt = cur;
      case (cur)
         MODE_OFF: begin
            if (code == EV_FOUR) nxt = MODE_TIME;
         end
         MODE_TIME: begin
            if (code == EV_FOUR) nxt = MODE_HOUR;
            else if (code == EV_EIGHT) nxt = MODE_OFF;
            else if (code == EV_FAST) nxt = MODE_SEC;
         end
         MODE_HOUR: begin
            if (code == EV_FOUR) nxt = MODE_MIN;
            else if (code == EV_EIGHT) nxt = MODE_OFF;
            else if (code == EV_IDLE) nxt = MODE_TIME;
         end
         MODE_MIN: begin
            if (code inside {EV_FOUR, EV_IDLE}) nxt = MODE_TIME;
            else if (code == EV_EIGHT) nxt = MODE_OFF;
         end
         MODE_SEC: begin
            if (code == EV_EIGHT) nxt = MODE_OFF;
            else if (code == EV_FAST) nxt = MODE_TIME;
         end
         default: begin
            nxt = cur;
         end
      endcase
      return nxt;
   endfunction

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_limit_ff   <= RST_FAST_PRESS_LIMIT;
         long_limit_ff   <= RST_LONG_PRESS_LIMIT;
         idle_limit_ff   <= RST_IDLE_LIMIT;
         blink_period_ff <= RST_BLINK_PERIOD;
         on_show_ff      <= RST_ON_TICKS_SHOW_TIME;
         on_adjust_ff    <= RST_ON_TICKS_ADJUST;
         on_seconds_ff   <= RST_ON_TICKS_SECONDS;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FAST_PRESS_LIMIT:   fast_limit_ff   <= csr_wdata;
            CSR_LONG_PRESS_LIMIT:   long_limit_ff   <= csr_wdata;
            CSR_IDLE_LIMIT:         idle_limit_ff   <= csr_wdata;
            CSR_BLINK_PERIOD:       blink_period_ff <= csr_wdata;
            CSR_ON_TICKS_SHOW_TIME: on_show_ff      <= csr_wdata;
            CSR_ON_TICKS_ADJUST:    on_adjust_ff    <= csr_wdata;
            CSR_ON_TICKS_SECONDS:   on_seconds_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      red_in         = red_ff;
      green_in       = green_ff;
      blink_count_in = blink_count_ff;
      on_ticks_in    = on_ticks_ff;
      blink_leds_in  = blink_leds_ff;
      press_count_in = press_count_ff;
      idle_count_in  = idle_count_ff;
      sampler_on_in  = sampler_on_ff;
      raise          = 1'b0;
      ev             = EV_NONE;
      target_mode    = mode_ff;
      // One bit wider so that a count of 255 plus one still ends the cycle.
      blink_next     = {1'b0, blink_count_ff} + {{COUNT_W{1'b0}}, 1'b1};

      if (accept) begin
         if (req_op == OP_BLINK) begin
            if (mode_ff != MODE_OFF) begin
               if (blink_next <= {1'b0, on_ticks_ff}) begin
                  if (blink_leds_ff[LED_RED_BIT]) red_in = 1'b1;
                  if (blink_leds_ff[LED_GREEN_BIT]) green_in = 1'b1;
                  blink_count_in = blink_next[COUNT_W-1:0];
               end else if (blink_next < {1'b0, blink_period_ff}) begin
                  if (blink_leds_ff[LED_RED_BIT]) red_in = 1'b0;
                  if (blink_leds_ff[LED_GREEN_BIT]) green_in = 1'b0;
                  blink_count_in = blink_next[COUNT_W-1:0];
               end else begin
                  blink_count_in = '0;
               end
            end
         end else if (!sampler_on_ff) begin
            // The waking sample is not counted.
            if (req_button_pressed) sampler_on_in = 1'b1;
         end else if (req_button_pressed) begin
            idle_count_in  = '0;
            press_count_in = press_count_ff + 8'd1;
            if (press_count_in == WARN_OFF_FIRST || press_count_in == WARN_OFF_LAST) begin
               red_in   = 1'b0;
               green_in = 1'b0;
            end else if (press_count_in == WARN_ON) begin
               red_in   = 1'b1;
               green_in = 1'b1;
            end
            raise = (press_count_in == long_limit_ff);
         end else begin
            idle_count_in = idle_count_ff + 8'd1;
            raise = (idle_count_in == idle_limit_ff) || (press_count_ff != '0);
         end

         if (raise) begin
            ev = sort_event(press_count_in, idle_count_in, fast_limit_ff, long_limit_ff,
                            idle_limit_ff);
            target_mode    = step_mode(mode_ff, ev);
            red_in         = 1'b0;
            green_in       = 1'b0;
            blink_count_in = '0;
            press_count_in = '0;
            idle_count_in  = '0;
            mode_in        = target_mode;
            case (target_mode)
               MODE_TIME: begin
                  blink_leds_in = LED_BOTH;
                  on_ticks_in   = on_show_ff;
               end
               MODE_HOUR: begin
                  blink_leds_in = LED_RED;
                  on_ticks_in   = on_adjust_ff;
               end
               MODE_MIN: begin
                  blink_leds_in = LED_GREEN;
                  on_ticks_in   = on_adjust_ff;
               end
               MODE_SEC: begin
                  blink_leds_in = LED_BOTH;
                  on_ticks_in   = on_seconds_ff;
               end
               default: begin
                  mode_in       = MODE_OFF;
                  blink_leds_in = LED_NONE;
                  sampler_on_in = 1'b0;
               end
            endcase
         end
      end

      result.red_led    = red_in;
      result.green_led  = green_in;
      result.mode       = mode_in;
      result.event_code = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_OFF;
         red_ff         <= 1'b0;
         green_ff       <= 1'b0;
         blink_count_ff <= '0;
         on_ticks_ff    <= '0;
         blink_leds_ff  <= LED_NONE;
         press_count_ff <= '0;
         idle_count_ff  <= '0;
         sampler_on_ff  <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         red_ff         <= red_in;
         green_ff       <= green_in;
         blink_count_ff <= blink_count_in;
         on_ticks_ff    <= on_ticks_in;
         blink_leds_ff  <= blink_leds_in;
         press_count_ff <= press_count_in;
         idle_count_ff  <= idle_count_in;
         sampler_on_ff  <= sampler_on_in;
      end
   end

   // The skid entry fills only while the output beat is stalled, and it
   // always moves up before a new request is taken, so order is kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
         end else if (accept) begin
            rsp_data_ff <= result;
         end
      end else if (accept) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_led    = rsp_data_ff.red_led;
   assign rsp_green_led  = rsp_data_ff.green_led;
   assign rsp_mode       = rsp_data_ff.mode;
   assign rsp_event_code = rsp_data_ff.event_code;

endmodule

// ===== rtl/obmc_checker.sv =====
// ----------------------------------------------------------------------------
// One-button mode controller checker
// Port-level properties of the controller, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "one_button_mode_controller_defines.svh"

module obmc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_red_led,
   input logic                             rsp_green_led,
   input logic [obmc_pkg::MODE_W-1:0]      rsp_mode,
   input logic [obmc_pkg::EVENT_W-1:0]     rsp_event_code
);
   import obmc_pkg::*;

   logic                        rsp_held;
   logic                        rsp_event;
   logic                        rsp_eight;
   logic                        leds_off;
   logic [MODE_W+EVENT_W+1:0]   rsp_beat;

   assign rsp_held  = rsp_valid && rsp_stall;
   assign rsp_beat  = {rsp_red_led, rsp_green_led, rsp_mode, rsp_event_code};
   assign rsp_event = rsp_valid && (rsp_event_code != EV_NONE);
   assign rsp_eight = rsp_valid && (rsp_event_code == EV_EIGHT);
   assign leds_off  = !rsp_red_led && !rsp_green_led;

   // A stalled result beat stays offered and unchanged.
   `OBMC_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_beat), "stalled beat changed")

   // The request side stalls only while a result beat is waiting.
   `OBMC_ASSERT_NOW(a_stall_full, req_stall, rsp_valid, "request stalled with empty output")

   // Entering a mode on any event turns both LEDs off.
   `OBMC_ASSERT_NOW(a_event_leds, rsp_event, leds_off, "LED on after event")

   // An eight-second press always ends in off mode.
   `OBMC_ASSERT_NOW(a_eight_off, rsp_eight, rsp_mode == MODE_OFF, "eight-second event not off")

endmodule

bind one_button_mode_controller obmc_checker u_obmc_checker (.*);
